### rtl/rolling_window_zscore_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the rolling window z-score block
// Implication checks that can be compiled out by defining ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef ROLLING_WINDOW_ZSCORE_ASSERT_SVH
`define ROLLING_WINDOW_ZSCORE_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication.
`define RWZ_ASSERT_IMP(lbl, ck, rs, a, c) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |-> (c)) \
    else $error("rwz assertion failed");
// Next-cycle implication.
`define RWZ_ASSERT_NXT(lbl, ck, rs, a, c) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |=> (c)) \
    else $error("rwz assertion failed");
`else
`define RWZ_ASSERT_IMP(lbl, ck, rs, a, c)
`define RWZ_ASSERT_NXT(lbl, ck, rs, a, c)
`endif
`endif

### rtl/rwz_pkg.sv
// ----------------------------------------------------------------------------
// Rolling window z-score package
// Beat types, operation codes and fixed constants shared by the block.
// ----------------------------------------------------------------------------
package rwz_pkg;

  localparam int SAMPLE_W = 24;
  localparam int LEN_W    = 9;
  localparam int CNT_W    = 8;
  localparam int ZN_W     = 41;

  localparam logic [LEN_W-1:0] LEN_RESET = 9'd20;
  localparam logic [22:0] STD_MAX = 23'h7FFFFF;
  localparam logic signed [23:0] Z_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] Z_MIN = 24'sh800000;

  localparam logic [1:0] OP_MUL  = 2'd0;
  localparam logic [1:0] OP_DIV  = 2'd1;
  localparam logic [1:0] OP_SQRT = 2'd2;

  typedef struct packed {
    logic signed [23:0] sample;
    logic               series_start;
  } rwz_in_t;

  typedef struct packed {
    logic               mean_valid;
    logic signed [23:0] window_mean;
    logic               std_valid;
    logic [22:0]        window_std;
    logic               z_valid;
    logic signed [23:0] z_score;
  } rwz_out_t;

  typedef struct packed {
    logic             start;
    logic [1:0]       op;
    logic [CNT_W-1:0] len;
  } arith_req_t;

endpackage

### rtl/rwz_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rwz_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/rwz_arith.sv
// ----------------------------------------------------------------------------
// Shared iterative arithmetic unit
// Shift-add multiply, restoring divide and digit-by-digit square root, all on
// one adder, one bit (or one root digit) per cycle.
// ----------------------------------------------------------------------------
module rwz_arith #(
  parameter int W = 66
) (
  input  logic                clk,
  input  logic                rst,
  input  rwz_pkg::arith_req_t req,
  input  logic [W-1:0]        a,
  input  logic [W-1:0]        b,
  output logic                done,
  output logic [W-1:0]        result
);
  import rwz_pkg::*;

  `include "rolling_window_zscore_assert.svh"

  logic             busy;
  logic [1:0]       op;
  logic [CNT_W-1:0] cnt;
  logic [W-1:0]     acc;
  logic [W-1:0]     ra;
  logic [W-1:0]     rb;
  logic [W-1:0]     q;
  logic             sub;
  logic [W:0]       x;
  logic [W:0]       y;
  logic [W+1:0]     s;
  logic             ge;

  // Dividends and radicands are expected left aligned in a.
  always_comb begin
    case (op)
      OP_MUL: begin
        sub = 1'b0;
        x   = {1'b0, acc};
        y   = {1'b0, ra};
      end
      OP_DIV: begin
        sub = 1'b1;
        x   = {acc, ra[W-1]};
        y   = {1'b0, rb};
      end
      OP_SQRT: begin
        sub = 1'b1;
        x   = {acc[W-2:0], ra[W-1:W-2]};
        y   = {q[W-2:0], 2'b01};
      end
      default: begin
        sub = 1'b0;
        x   = '0;
        y   = '0;
      end
    endcase
    s  = {1'b0, x} + {1'b0, y ^ {(W+1){sub}}} + (W+2)'(sub);
    ge = s[W+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy <= 1'b1;
        op   <= req.op;
        cnt  <= req.len;
        acc  <= '0;
        q    <= '0;
        ra   <= a;
        rb   <= b;
      end else if (busy) begin
        case (op)
          OP_MUL: begin
            if (rb[0]) begin
              acc <= s[W-1:0];
            end
            ra <= ra << 1;
            rb <= rb >> 1;
          end
          OP_DIV: begin
            acc <= ge ? s[W-1:0] : x[W-1:0];
            q   <= {q[W-2:0], ge};
            ra  <= ra << 1;
          end
          OP_SQRT: begin
            acc <= ge ? s[W-1:0] : x[W-1:0];
            q   <= {q[W-2:0], ge};
            ra  <= ra << 2;
          end
          default: begin
            acc <= acc;
          end
        endcase
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign result = (op == OP_MUL) ? acc : q;

  `RWZ_ASSERT_IMP(a_start_when_free, clk, rst, req.start, !busy)
  `RWZ_ASSERT_IMP(a_done_ends_busy, clk, rst, done, !busy)
  `RWZ_ASSERT_NXT(a_done_pulse, clk, rst, done, !done)

endmodule

### rtl/rolling_window_zscore.sv
// ----------------------------------------------------------------------------
// Rolling window z-score
// Keeps the last N samples in a ring with a running sum and sum of squares and
// reports for each sample the window mean, sample standard deviation and z-score,
// flagged valid once the window has filled.
//  Channel  Handshake            Beat
//  item     item_valid/stall     sample, series_start
//  result   result_valid/stall   three flags with mean, deviation, z-score
//  cfg      cfg_valid/ready      window_length (9 bits), restarts the series
//
// A sample holds the block until its result is put in the output register. While
// the window is still filling it passes through load, the update states and the
// final state; with length zero it goes from load straight to the final state.
// With a full window the shared arithmetic unit, resolving one bit or one root
// digit per cycle, runs seven operations in turn (fewer when the deviation or
// z-score is skipped), each issued and then waited for.
// Reset is synchronous; it restores the length of 20 and an empty series.
// A result waits in its output register while result_stall is high; the next
// sample is already accepted then and only its final hand-off waits.
// ----------------------------------------------------------------------------
module rolling_window_zscore #(
  parameter int MAX_WINDOW = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  rwz_pkg::rwz_in_t  item,
  output logic              result_valid,
  input  logic              result_stall,
  output rwz_pkg::rwz_out_t result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [8:0]        cfg_data
);
  import rwz_pkg::*;

  `include "rolling_window_zscore_assert.svh"

  // Count width holds the depth itself; the ring index only the slots.
  localparam int CW    = $clog2(MAX_WINDOW + 1);
  localparam int AW    = $clog2(MAX_WINDOW);
  localparam int SUM_W = SAMPLE_W + CW;
  localparam int SQ_W  = 47 + CW;
  localparam int W     = 48 + 2 * CW;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LOAD  = 4'd1;
  localparam logic [3:0] S_UPD   = 4'd2;
  localparam logic [3:0] S_UPD2  = 4'd3;
  localparam logic [3:0] S_ISSUE = 4'd4;
  localparam logic [3:0] S_WAIT  = 4'd5;
  localparam logic [3:0] S_FIN   = 4'd6;

  // Operations of the statistics sequence, in issue order.
  localparam logic [2:0] K_NSQ  = 3'd0;
  localparam logic [2:0] K_SQR  = 3'd1;
  localparam logic [2:0] K_MEAN = 3'd2;
  localparam logic [2:0] K_NN1  = 3'd3;
  localparam logic [2:0] K_VAR  = 3'd4;
  localparam logic [2:0] K_ROOT = 3'd5;
  localparam logic [2:0] K_Z    = 3'd6;

  logic [3:0]              state;
  logic [2:0]              k;
  logic [LEN_W-1:0]        window_length;
  logic [CW-1:0]           n;
  logic [AW-1:0]           write_slot;
  logic [CW-1:0]           seen_count;
  logic signed [SUM_W-1:0] running_sum;
  logic [SQ_W-1:0]         running_square_sum;
  logic signed [23:0]      x;
  logic [46:0]             xsq;
  logic signed [23:0]      old;
  logic [46:0]             oldsq;
  logic [AW-1:0]           slot;
  logic [AW-1:0]           slot_c;
  logic [W-1:0]            p1;
  logic [W-1:0]            dreg;
  logic [W-1:0]            nn;
  logic [W-1:0]            root;
  rwz_out_t                pend;

  logic signed [47:0]      x_prod;
  logic signed [47:0]      old_prod;
  logic signed [23:0]      ram_s;
  logic [23:0]             ram_rdata;
  logic                    ram_we;
  logic                    ram_re;
  logic                    full;
  logic                    sum_neg;
  logic [SUM_W-1:0]        sum_mag;
  logic signed [24:0]      zdiff;
  logic                    zneg;
  logic [24:0]             zmag;
  logic [ZN_W-1:0]         zq;
  logic signed [23:0]      mean_c;
  logic signed [23:0]      z_c;

  arith_req_t              req;
  logic [W-1:0]            op_a;
  logic [W-1:0]            op_b;
  logic                    ar_done;
  logic [W-1:0]            ar_res;

  logic                    item_acc;
  logic                    cfg_acc;

  assign item_stall = (state != S_IDLE);
  assign cfg_ready  = (state == S_IDLE);
  assign item_acc   = item_valid && !item_stall;
  assign cfg_acc    = cfg_valid && cfg_ready;

  // Lengths beyond the ring depth are clamped to it.
  assign n = (32'(window_length) > MAX_WINDOW) ? CW'(MAX_WINDOW) : CW'(window_length);

  assign slot_c  = (CW'(write_slot) < n) ? write_slot : '0;
  assign full    = (seen_count >= n);
  assign x_prod  = x * x;
  assign ram_s   = $signed(ram_rdata);
  assign old_prod = ram_s * ram_s;
  assign ram_re  = (state == S_LOAD);
  assign ram_we  = (state == S_UPD2);

  assign sum_neg = running_sum[SUM_W-1];
  assign sum_mag = sum_neg ? SUM_W'(-running_sum) : SUM_W'(running_sum);

  // Centered sample for the z-score, as a magnitude and a sign.
  assign zdiff = 25'(x) - 25'(pend.window_mean);
  assign zneg  = zdiff[24];
  assign zmag  = zneg ? 25'(-zdiff) : 25'(zdiff);
  assign zq    = ar_res[ZN_W-1:0];

  assign mean_c = sum_neg ? -$signed(ar_res[23:0]) : $signed(ar_res[23:0]);

  always_comb begin
    if (zneg) begin
      z_c = (zq > ZN_W'(24'h800000)) ? Z_MIN : -$signed(zq[23:0]);
    end else begin
      z_c = (zq > ZN_W'(Z_MAX)) ? Z_MAX : $signed(zq[23:0]);
    end
  end

  // Operand selection for the shared unit.
  always_comb begin
    req.start = (state == S_ISSUE);
    req.op    = OP_MUL;
    req.len   = CNT_W'(CW);
    op_a      = '0;
    op_b      = '0;
    case (k)
      K_NSQ: begin
        op_a = W'(running_square_sum);
        op_b = W'(n);
      end
      K_SQR: begin
        req.len = CNT_W'(SUM_W);
        op_a    = W'(sum_mag);
        op_b    = W'(sum_mag);
      end
      K_MEAN: begin
        req.op  = OP_DIV;
        req.len = CNT_W'(SUM_W);
        op_a    = W'(sum_mag) << (W - SUM_W);
        op_b    = W'(n);
      end
      K_NN1: begin
        op_a = W'(n - CW'(1));
        op_b = W'(n);
      end
      K_VAR: begin
        req.op  = OP_DIV;
        req.len = CNT_W'(W);
        op_a    = dreg;
        op_b    = nn;
      end
      K_ROOT: begin
        // The quotient of the variance step is still held at the unit output.
        req.op  = OP_SQRT;
        req.len = CNT_W'(W / 2);
        op_a    = ar_res;
      end
      K_Z: begin
        req.op  = OP_DIV;
        req.len = CNT_W'(ZN_W);
        op_a    = W'({zmag, 16'h0000}) << (W - ZN_W);
        op_b    = root;
      end
      default: begin
        req.len = CNT_W'(CW);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      window_length      <= LEN_RESET;
      write_slot         <= '0;
      seen_count         <= '0;
      running_sum        <= '0;
      running_square_sum <= '0;
      result_valid       <= 1'b0;
    end else begin
      // A beat taken while a new one is loaded is replaced in the final state.
      if (result_valid && !result_stall && (state != S_FIN)) begin
        result_valid <= 1'b0;
      end
      if (cfg_acc) begin
        window_length <= cfg_data;
      end
      // Any length write, or a beat that opens a new series, empties the window.
      if (cfg_acc || (item_acc && item.series_start)) begin
        write_slot         <= '0;
        seen_count         <= '0;
        running_sum        <= '0;
        running_square_sum <= '0;
      end
      case (state)
        S_IDLE: begin
          if (item_acc) begin
            x     <= item.sample;
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          pend <= '0;
          slot <= slot_c;
          xsq  <= x_prod[46:0];
          state <= (n == '0) ? S_FIN : S_UPD;
        end
        S_UPD: begin
          old   <= ram_s;
          oldsq <= old_prod[46:0];
          state <= S_UPD2;
        end
        S_UPD2: begin
          // Drop the oldest sample once the window is full, then add this one.
          running_sum <= running_sum + SUM_W'(x) - (full ? SUM_W'(old) : '0);
          running_square_sum <= running_square_sum + SQ_W'(xsq)
                                - (full ? SQ_W'(oldsq) : '0);
          if (!full) begin
            seen_count <= seen_count + CW'(1);
          end
          write_slot <= (CW'(slot) + CW'(1) >= n) ? '0 : slot + AW'(1);
          if (full || (seen_count + CW'(1) >= n)) begin
            k     <= K_NSQ;
            state <= S_ISSUE;
          end else begin
            state <= S_FIN;
          end
        end
        S_ISSUE: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (ar_done) begin
            case (k)
              K_NSQ: begin
                p1    <= ar_res;
                k     <= K_SQR;
                state <= S_ISSUE;
              end
              K_SQR: begin
                // N * sumsq - sum^2, floored at zero.
                dreg  <= (p1 > ar_res) ? (p1 - ar_res) : '0;
                k     <= K_MEAN;
                state <= S_ISSUE;
              end
              K_MEAN: begin
                pend.mean_valid  <= 1'b1;
                pend.window_mean <= mean_c;
                if (n < CW'(2)) begin
                  state <= S_FIN;
                end else begin
                  k     <= K_NN1;
                  state <= S_ISSUE;
                end
              end
              K_NN1: begin
                nn    <= ar_res;
                k     <= K_VAR;
                state <= S_ISSUE;
              end
              K_VAR: begin
                k     <= K_ROOT;
                state <= S_ISSUE;
              end
              K_ROOT: begin
                root           <= ar_res;
                pend.std_valid <= 1'b1;
                pend.window_std <= (ar_res > W'(STD_MAX)) ? STD_MAX : ar_res[22:0];
                if (ar_res == '0) begin
                  state <= S_FIN;
                end else begin
                  k     <= K_Z;
                  state <= S_ISSUE;
                end
              end
              K_Z: begin
                pend.z_valid <= 1'b1;
                pend.z_score <= z_c;
                state        <= S_FIN;
              end
              default: begin
                state <= S_FIN;
              end
            endcase
          end
        end
        S_FIN: begin
          if (!result_valid || !result_stall) begin
            result       <= pend;
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  rwz_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MAX_WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot),
    .wdata (x),
    .re    (ram_re),
    .raddr (slot_c),
    .rdata (ram_rdata)
  );

  rwz_arith #(
    .W (W)
  ) u_arith (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .a      (op_a),
    .b      (op_b),
    .done   (ar_done),
    .result (ar_res)
  );

  `RWZ_ASSERT_IMP(a_slot_in_window, clk, rst, (state == S_IDLE) && (n != '0), CW'(write_slot) < n)
  `RWZ_ASSERT_IMP(a_seen_bound, clk, rst, (state == S_IDLE) && (n != '0), seen_count <= n)
  `RWZ_ASSERT_IMP(a_flag_chain, clk, rst, result_valid && result.z_valid, result.std_valid && result.mean_valid)

endmodule
